FILE: src/tttf_pkg.sv
// ----------------------------------------------------------------------------
// tttf_pkg
// Shared types and constants of the tap tempo triangle fader: register
// indexes, reset values, controller states and the control/status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package tttf_pkg;

  // default fixed-point and time-stamp widths
  localparam int DEF_PHASE_FRAC_BITS = 16;
  localparam int DEF_TIME_BITS       = 32;

  // field widths
  localparam int INTENSITY_W = 16;
  localparam int PERIOD_W    = 12;
  localparam int DEBOUNCE_W  = 8;
  localparam int NOW_W       = 32;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_INTENSITY_LOW  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_INTENSITY_HIGH = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_PERIOD     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_PERIOD     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE       = 3'd4;

  // reset values
  localparam logic [INTENSITY_W-1:0] RST_INTENSITY_LOW  = 16'd0;
  localparam logic [INTENSITY_W-1:0] RST_INTENSITY_HIGH = 16'd65535;
  localparam logic [PERIOD_W-1:0]    RST_MIN_PERIOD     = 12'd60;
  localparam logic [PERIOD_W-1:0]    RST_MAX_PERIOD     = 12'd3000;
  localparam logic [DEBOUNCE_W-1:0]  RST_DEBOUNCE       = 8'd50;
  localparam logic [PERIOD_W-1:0]    RST_PERIOD         = 12'd1000;

  // operation codes
  localparam logic OP_FADE  = 1'b0;
  localparam logic OP_PRESS = 1'b1;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_UPDATE,
    ST_MULT,
    ST_SCALE
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;       // take the input beat
    logic div_step;   // one quotient bit
    logic phase_upd;  // reflect and store the new phase
    logic mul;        // register span * phase
    logic emit;       // write the result register
  } ctrl_t;

  // status from datapath to controller
  typedef struct packed {
    logic div_last;   // final quotient bit this cycle
    logic out_free;   // result register can take a new beat
  } stat_t;

endpackage

`default_nettype wire

FILE: src/tttf_ctrl.sv
// ----------------------------------------------------------------------------
// tttf_ctrl
// Sequencer of the fader: accepts one beat, runs the divider and phase
// update for a fade event, then multiply, scale and result write.
// ----------------------------------------------------------------------------
`default_nettype none

module tttf_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire logic            operation,
  output logic                 in_stall,
  input  wire tttf_pkg::stat_t stat,
  output tttf_pkg::ctrl_t      ctrl
);

  tttf_pkg::state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tttf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    ctrl       = '0;
    in_stall   = 1'b1;
    unique case (state)
      tttf_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ctrl.load  = 1'b1;
          state_next = (operation == tttf_pkg::OP_PRESS) ? tttf_pkg::ST_MULT
                                                         : tttf_pkg::ST_DIVIDE;
        end
      end
      tttf_pkg::ST_DIVIDE: begin
        ctrl.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = tttf_pkg::ST_UPDATE;
        end
      end
      tttf_pkg::ST_UPDATE: begin
        ctrl.phase_upd = 1'b1;
        state_next     = tttf_pkg::ST_MULT;
      end
      tttf_pkg::ST_MULT: begin
        ctrl.mul   = 1'b1;
        state_next = tttf_pkg::ST_SCALE;
      end
      tttf_pkg::ST_SCALE: begin
        if (stat.out_free) begin
          ctrl.emit  = 1'b1;
          state_next = tttf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tttf_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: src/tttf_datapath.sv
// ----------------------------------------------------------------------------
// tttf_datapath
// Configuration registers, fader state, bit-serial step divider, phase
// reflection, intensity multiplier and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tttf_datapath #(
  parameter int PHASE_FRAC_BITS = tttf_pkg::DEF_PHASE_FRAC_BITS,
  parameter int TIME_BITS       = tttf_pkg::DEF_TIME_BITS
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [tttf_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [tttf_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                                operation,
  input  wire logic [tttf_pkg::NOW_W-1:0]          now_ms,
  input  wire tttf_pkg::ctrl_t                     ctrl,
  output tttf_pkg::stat_t                          stat,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [tttf_pkg::INTENSITY_W-1:0]         intensity,
  output logic [tttf_pkg::PERIOD_W-1:0]            period_ms,
  output logic                                     tempo_updated,
  output logic                                     press_accepted
);

  localparam int F   = PHASE_FRAC_BITS;
  localparam int TB  = TIME_BITS;
  localparam int PHW = F + 1;           // phase, 0 .. ONE
  localparam int QW  = F + 2;           // saturating quotient
  localparam int W   = F + 3;           // phase arithmetic
  localparam int D   = TB + F + 1;      // dividend bits
  localparam int CW  = $clog2(D);
  localparam int PW  = tttf_pkg::INTENSITY_W + 1 + F + 2;
  localparam int RW  = tttf_pkg::PERIOD_W + 1;

  localparam logic [W-1:0]   ONE_W = W'(1) << F;
  localparam logic [W-1:0]   TWO_W = W'(1) << (F + 1);
  localparam logic [PHW-1:0] ONE_P = PHW'(1) << F;

  // configuration registers
  logic [tttf_pkg::INTENSITY_W-1:0] intensity_low;
  logic [tttf_pkg::INTENSITY_W-1:0] intensity_high;
  logic [tttf_pkg::PERIOD_W-1:0]    min_period;
  logic [tttf_pkg::PERIOD_W-1:0]    max_period;
  logic [tttf_pkg::DEBOUNCE_W-1:0]  debounce_window;

  // fader state
  logic [PHW-1:0]                phase;
  logic                          falling;
  logic [TB-1:0]                 last_fade_time;
  logic [tttf_pkg::PERIOD_W-1:0] period;
  logic [TB-1:0]                 last_press_stamp;
  logic [TB-1:0]                 last_tap_stamp;
  logic                          updated;
  logic                          accepted;

  // divider
  logic [D-1:0]  dividend;
  logic [RW-1:0] rem;
  logic [QW-1:0] quot;
  logic          sticky;
  logic [CW-1:0] cnt;

  // multiplier
  logic signed [PW-1:0] prod;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      intensity_low   <= tttf_pkg::RST_INTENSITY_LOW;
      intensity_high  <= tttf_pkg::RST_INTENSITY_HIGH;
      min_period      <= tttf_pkg::RST_MIN_PERIOD;
      max_period      <= tttf_pkg::RST_MAX_PERIOD;
      debounce_window <= tttf_pkg::RST_DEBOUNCE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tttf_pkg::REG_INTENSITY_LOW:  intensity_low   <= cfg_data;
        tttf_pkg::REG_INTENSITY_HIGH: intensity_high  <= cfg_data;
        tttf_pkg::REG_MIN_PERIOD:     min_period      <= cfg_data[tttf_pkg::PERIOD_W-1:0];
        tttf_pkg::REG_MAX_PERIOD:     max_period      <= cfg_data[tttf_pkg::PERIOD_W-1:0];
        tttf_pkg::REG_DEBOUNCE:       debounce_window <= cfg_data[tttf_pkg::DEBOUNCE_W-1:0];
        default: ;
      endcase
    end
  end

  // input beat decode
  logic [TB-1:0]                 now_in;
  logic [TB-1:0]                 fade_base;
  logic [TB-1:0]                 elapsed;
  logic [TB-1:0]                 press_gap;
  logic [TB-1:0]                 tap_gap;
  logic [tttf_pkg::PERIOD_W-1:0] lo_limit;
  logic                          press_ok;
  logic                          tap_in_range;

  always_comb begin
    now_in       = now_ms[TB-1:0];
    fade_base    = (last_fade_time == '0) ? now_in : last_fade_time;
    elapsed      = now_in - fade_base;
    press_gap    = now_in - last_press_stamp;
    tap_gap      = now_in - last_tap_stamp;
    lo_limit     = (min_period == '0) ? tttf_pkg::PERIOD_W'(1) : min_period;
    press_ok     = press_gap >= TB'(debounce_window);
    tap_in_range = (last_tap_stamp != '0) && (tap_gap >= TB'(lo_limit))
                   && (tap_gap <= TB'(max_period));
  end

  // restoring divider step
  logic [RW-1:0] rem_sh;
  logic          q_bit;

  always_comb begin
    rem_sh = {rem[RW-2:0], dividend[D-1]};
    q_bit  = rem_sh >= {1'b0, period};
  end

  // phase reflection
  logic [W-1:0]   ph_w;
  logic [W-1:0]   step_w;
  logic [W-1:0]   sum_w;
  logic [W-1:0]   top_w;
  logic [W-1:0]   bot_w;
  logic [PHW-1:0] phase_next;
  logic           falling_next;

  always_comb begin
    ph_w         = W'(phase);
    step_w       = sticky ? W'({QW{1'b1}}) : W'(quot);
    sum_w        = ph_w + step_w;
    top_w        = TWO_W - sum_w;
    bot_w        = step_w - ph_w;
    phase_next   = phase;
    falling_next = falling;
    if (!falling) begin
      if (sum_w >= ONE_W) begin
        // reflect at full scale, clamp an overshoot past zero
        falling_next = 1'b1;
        phase_next   = (sum_w > TWO_W) ? '0 : top_w[PHW-1:0];
      end else begin
        phase_next = sum_w[PHW-1:0];
      end
    end else begin
      if (step_w > ph_w) begin
        // reflect at zero, clamp an overshoot past full scale
        falling_next = 1'b0;
        phase_next   = (bot_w > ONE_W) ? ONE_P : bot_w[PHW-1:0];
      end else begin
        phase_next = PHW'(ph_w - step_w);
      end
    end
  end

  // scaled intensity, product truncated toward zero
  logic signed [tttf_pkg::INTENSITY_W:0] span;
  logic signed [F+1:0]                   phase_s;
  logic signed [PW-1:0]                  prod_adj;
  logic signed [PW-1:0]                  prod_sh;
  logic [tttf_pkg::INTENSITY_W-1:0]      intensity_next;

  always_comb begin
    span     = $signed({1'b0, intensity_high}) - $signed({1'b0, intensity_low});
    phase_s  = $signed({1'b0, phase});
    prod_adj = prod[PW-1] ? (prod + $signed({{(PW-F){1'b0}}, {F{1'b1}}})) : prod;
    prod_sh  = prod_adj >>> F;
    intensity_next = intensity_low + prod_sh[tttf_pkg::INTENSITY_W-1:0];
  end

  // fader state and tap tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= '0;
      falling          <= 1'b0;
      last_fade_time   <= '0;
      period           <= tttf_pkg::RST_PERIOD;
      last_press_stamp <= '0;
      last_tap_stamp   <= '0;
      updated          <= 1'b0;
      accepted         <= 1'b0;
    end else begin
      if (ctrl.load) begin
        updated  <= 1'b0;
        accepted <= 1'b0;
        if (operation == tttf_pkg::OP_FADE) begin
          last_fade_time <= now_in;
        end else if (press_ok) begin
          accepted         <= 1'b1;
          last_press_stamp <= now_in;
          last_tap_stamp   <= now_in;
          if (tap_in_range) begin
            period  <= tap_gap[tttf_pkg::PERIOD_W-1:0];
            updated <= 1'b1;
          end
        end
      end
      if (ctrl.phase_upd) begin
        phase   <= phase_next;
        falling <= falling_next;
      end
    end
  end

  // divider registers
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      dividend <= {elapsed, {(F + 1){1'b0}}};
      rem      <= '0;
      quot     <= '0;
      sticky   <= 1'b0;
      cnt      <= CW'(D - 1);
    end else if (ctrl.div_step) begin
      dividend <= {dividend[D-2:0], 1'b0};
      rem      <= q_bit ? (rem_sh - {1'b0, period}) : rem_sh;
      quot     <= {quot[QW-2:0], q_bit};
      sticky   <= sticky | quot[QW-1];
      cnt      <= cnt - CW'(1);
    end
  end

  // product register
  always_ff @(posedge clk) begin
    if (ctrl.mul) begin
      prod <= span * phase_s;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      intensity      <= intensity_next;
      period_ms      <= period;
      tempo_updated  <= updated;
      press_accepted <= accepted;
    end
  end

  // status
  always_comb begin
    stat.div_last = cnt == '0;
    stat.out_free = !out_valid || !out_stall;
  end

endmodule

`default_nettype wire

FILE: src/tap_tempo_triangle_fader_top.sv
// ----------------------------------------------------------------------------
// tap_tempo_triangle_fader_top
// Order: a press beat runs multiply and scale after acceptance; a fade beat
// first runs the one-bit-per-cycle step divider and the phase update. The
// result is written once the result register is free. Throughput: one beat
// at a time; the next beat is taken the cycle after the result is written.
// Synchronous reset restores the configuration, fader and sequencer state.
// ----------------------------------------------------------------------------
`default_nettype none

module tap_tempo_triangle_fader_top #(
  parameter int PHASE_FRAC_BITS = tttf_pkg::DEF_PHASE_FRAC_BITS,
  parameter int TIME_BITS       = tttf_pkg::DEF_TIME_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [tttf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [tttf_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             operation,
  input  wire logic [tttf_pkg::NOW_W-1:0]       now_ms,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [tttf_pkg::INTENSITY_W-1:0]      intensity,
  output logic [tttf_pkg::PERIOD_W-1:0]         period_ms,
  output logic                                  tempo_updated,
  output logic                                  press_accepted
);

  tttf_pkg::ctrl_t ctrl;
  tttf_pkg::stat_t stat;

  // sequencer
  tttf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .operation (operation),
    .in_stall  (in_stall),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  // datapath
  tttf_datapath #(
    .PHASE_FRAC_BITS (PHASE_FRAC_BITS),
    .TIME_BITS       (TIME_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .operation      (operation),
    .now_ms         (now_ms),
    .ctrl           (ctrl),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .intensity      (intensity),
    .period_ms      (period_ms),
    .tempo_updated  (tempo_updated),
    .press_accepted (press_accepted)
  );

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the tap tempo triangle fader. Fade and press beats
// go in with random gaps while the result side stalls at random, but for the
// last two settings. A model of the triangle phase, direction and tap tracking
// predicts every result beat; each is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module tb;
  import tttf_pkg::*;

  localparam int     CLK_HALF     = 4;
  localparam int     FRAC         = DEF_PHASE_FRAC_BITS;
  localparam longint PHASE_FULL   = longint'(1) << FRAC;
  localparam int     N_ROWS       = 25;
  localparam int     N_SETTINGS   = 6;
  localparam int     RUN_ITEMS    = 85;
  localparam int     CYCLE_LIMIT  = 400000;
  localparam int     DRAIN_CYCLES = 64;

  typedef struct packed {
    logic [INTENSITY_W-1:0] intensity;
    logic [PERIOD_W-1:0]    period;
    logic                   updated;
    logic                   accepted;
  } fader_result_t;

  typedef struct packed {
    logic                op;
    logic [NOW_W-1:0]    stamp;
    logic                fixed;   // use the typed-in result below
    fader_result_t       want;
  } stim_row_t;

  localparam fader_result_t NO_WANT = '0;
  localparam fader_result_t AT_ZERO = '{16'd0, RST_PERIOD, 1'b0, 1'b0};
  localparam fader_result_t AT_FULL = '{16'd65535, RST_PERIOD, 1'b0, 1'b0};

  // dut ports
  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;
  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  logic                   operation = OP_FADE;
  logic [NOW_W-1:0]       now_ms    = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [INTENSITY_W-1:0] intensity;
  logic [PERIOD_W-1:0]    period_ms;
  logic                   tempo_updated;
  logic                   press_accepted;

  // register copies
  logic [INTENSITY_W-1:0] lvl_low;
  logic [INTENSITY_W-1:0] lvl_high;
  logic [PERIOD_W-1:0]    tap_min;
  logic [PERIOD_W-1:0]    tap_max;
  logic [DEBOUNCE_W-1:0]  deb_win;

  // fader and tap state
  logic [FRAC:0]          fade_phase;
  logic                   fade_down;
  logic [NOW_W-1:0]       last_fade_ms;
  logic [NOW_W-1:0]       last_press_ms;
  logic [NOW_W-1:0]       last_tap_ms;
  logic [PERIOD_W-1:0]    tempo_ms;

  fader_result_t due_results[$];
  fader_result_t head_result;
  int            snd_idle_pct = 0;
  int            rcv_idle_pct = 0;
  int            mismatches   = 0;

  // directed rows, walked in order right after reset
  stim_row_t dir_rows [N_ROWS] = '{
    '{OP_FADE,  32'd0,          1'b1, AT_ZERO},  // first fade after reset
    '{OP_FADE,  32'd250,        1'b1, AT_ZERO},  // zero stamp counts as no fade yet
    '{OP_FADE,  32'd500,        1'b0, NO_WANT},
    '{OP_FADE,  32'd750,        1'b1, AT_FULL},  // lands exactly on full scale
    '{OP_FADE,  32'd1000,       1'b0, NO_WANT},
    '{OP_FADE,  32'd1250,       1'b0, NO_WANT},  // lands exactly on zero, falling
    '{OP_FADE,  32'd1500,       1'b0, NO_WANT},  // reflects at the bottom
    '{OP_FADE,  32'd4500,       1'b0, NO_WANT},  // overshoot at top clamps to zero
    '{OP_FADE,  32'd7500,       1'b0, NO_WANT},  // overshoot at bottom clamps to full
    '{OP_FADE,  32'd7400,       1'b0, NO_WANT},  // elapsed time wraps
    '{OP_FADE,  32'hFFFF_FFFF,  1'b0, NO_WANT},
    '{OP_PRESS, 32'd0,          1'b0, NO_WANT},  // inside debounce window
    '{OP_PRESS, 32'd100,        1'b0, NO_WANT},  // first tap, nothing measured
    '{OP_PRESS, 32'd120,        1'b0, NO_WANT},  // bounce
    '{OP_PRESS, 32'd600,        1'b0, NO_WANT},  // adopt 500
    '{OP_PRESS, 32'd1100,       1'b0, NO_WANT},  // adopt the same period again
    '{OP_PRESS, 32'd1150,       1'b0, NO_WANT},  // below minimum
    '{OP_PRESS, 32'd4200,       1'b0, NO_WANT},  // above maximum
    '{OP_PRESS, 32'd7200,       1'b0, NO_WANT},  // exactly maximum
    '{OP_PRESS, 32'd7260,       1'b0, NO_WANT},  // exactly minimum
    '{OP_FADE,  32'd7300,       1'b0, NO_WANT},  // fade at the shortest period
    '{OP_PRESS, 32'hFFFF_FFFF,  1'b0, NO_WANT},
    '{OP_PRESS, 32'h0000_0031,  1'b0, NO_WANT},  // debounce across the wrap
    '{OP_FADE,  32'hAAAA_AAAA,  1'b0, NO_WANT},
    '{OP_PRESS, 32'h5555_5555,  1'b0, NO_WANT}
  };

  tap_tempo_triangle_fader_top u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .operation      (operation),
    .now_ms         (now_ms),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .intensity      (intensity),
    .period_ms      (period_ms),
    .tempo_updated  (tempo_updated),
    .press_accepted (press_accepted)
  );

  // clock
  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // state after reset
  task automatic fader_model_reset();
    lvl_low       = RST_INTENSITY_LOW;
    lvl_high      = RST_INTENSITY_HIGH;
    tap_min       = RST_MIN_PERIOD;
    tap_max       = RST_MAX_PERIOD;
    deb_win       = RST_DEBOUNCE;
    fade_phase    = '0;
    fade_down     = 1'b0;
    last_fade_ms  = '0;
    last_press_ms = '0;
    last_tap_ms   = '0;
    tempo_ms      = RST_PERIOD;
  endtask

  // advance the fader or the tap tracker by one event, return the result
  function automatic fader_result_t fader_advance(input logic op,
                                                  input logic [NOW_W-1:0] stamp);
    fader_result_t       res;
    logic [NOW_W-1:0]    gap_ms;
    logic [PERIOD_W-1:0] lo_lim;
    longint              step;
    longint              p;
    longint              span;
    res = '0;
    if (op == OP_FADE) begin
      if (last_fade_ms == '0) last_fade_ms = stamp;
      gap_ms = stamp - last_fade_ms;
      step   = (longint'(gap_ms) << (FRAC + 1)) / longint'(tempo_ms);
      if (!fade_down) begin
        p = longint'(fade_phase) + step;
        if (p >= PHASE_FULL) begin
          p = 2 * PHASE_FULL - p;
          fade_down = 1'b1;
          if (p < 0) p = 0;
        end
      end else begin
        p = longint'(fade_phase) - step;
        if (p < 0) begin
          p = -p;
          fade_down = 1'b0;
          if (p > PHASE_FULL) p = PHASE_FULL;
        end
      end
      fade_phase   = p[FRAC:0];
      last_fade_ms = stamp;
    end else begin
      gap_ms = stamp - last_press_ms;
      if (gap_ms >= deb_win) begin
        res.accepted  = 1'b1;
        last_press_ms = stamp;
        if (last_tap_ms != '0) begin
          gap_ms = stamp - last_tap_ms;
          lo_lim = (tap_min == '0) ? PERIOD_W'(1) : tap_min;
          if (gap_ms >= lo_lim && gap_ms <= tap_max) begin
            tempo_ms    = gap_ms[PERIOD_W-1:0];
            res.updated = 1'b1;
          end
        end
        last_tap_ms = stamp;
      end
    end
    // intensity from the new phase, product truncated toward zero
    span = longint'(lvl_high) - longint'(lvl_low);
    p    = longint'(lvl_low) + (span * longint'(fade_phase)) / PHASE_FULL;
    res.intensity = p[INTENSITY_W-1:0];
    res.period    = tempo_ms;
    return res;
  endfunction

  // queue one predicted result beat
  task automatic expect_result(input fader_result_t r);
    due_results.insert(due_results.size(), r);
  endtask

  // one register write, leaves cfg_we high
  task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx,
                         input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_INTENSITY_LOW:  lvl_low  = val;
      REG_INTENSITY_HIGH: lvl_high = val;
      REG_MIN_PERIOD:     tap_min  = val[PERIOD_W-1:0];
      REG_MAX_PERIOD:     tap_max  = val[PERIOD_W-1:0];
      REG_DEBOUNCE:       deb_win  = val[DEBOUNCE_W-1:0];
      default: ;
    endcase
  endtask

  // register settings for each random run
  task automatic apply_setting(input int k);
    logic [CFG_DATA_W-1:0] lo;
    logic [CFG_DATA_W-1:0] hi;
    logic [CFG_DATA_W-1:0] mn;
    logic [CFG_DATA_W-1:0] mx;
    logic [CFG_DATA_W-1:0] db;
    case (k)
      0: begin  // widest limits, no debounce
        lo = 16'd0; hi = 16'd65535; mn = 16'd1; mx = 16'd4095; db = 16'd0;
      end
      1: begin  // reversed range, zero minimum, longest debounce
        lo = 16'd65535; hi = 16'd0; mn = 16'd0; mx = 16'd100; db = 16'd255;
      end
      2: begin  // crossed limits
        lo = CFG_DATA_W'($urandom_range(65535));
        hi = CFG_DATA_W'($urandom_range(65535));
        mn = 16'd500; mx = 16'd200;
        db = CFG_DATA_W'($urandom_range(255));
      end
      3: begin
        lo = CFG_DATA_W'($urandom_range(65535));
        hi = CFG_DATA_W'($urandom_range(65535));
        mn = CFG_DATA_W'($urandom_range(1, 400));
        mx = CFG_DATA_W'($urandom_range(400, 4095));
        db = CFG_DATA_W'($urandom_range(80));
      end
      4: begin  // flat output, single accepted period
        lo = 16'd65535; hi = 16'd65535; mn = 16'd4095; mx = 16'd4095; db = 16'd1;
      end
      default: begin
        lo = CFG_DATA_W'($urandom_range(65535)); hi = 16'd0;
        mn = CFG_DATA_W'($urandom_range(4095));
        mx = CFG_DATA_W'($urandom_range(4095));
        db = CFG_DATA_W'($urandom_range(255));
      end
    endcase
    put_reg(REG_INTENSITY_LOW, lo);
    put_reg(REG_INTENSITY_HIGH, hi);
    put_reg(REG_MIN_PERIOD, mn);
    put_reg(REG_MAX_PERIOD, mx);
    put_reg(REG_DEBOUNCE, db);
    cfg_we <= 1'b0;
  endtask

  // drive one input beat after a random gap, predict once it is taken
  task automatic send_beat(input logic op, input logic [NOW_W-1:0] stamp,
                           output fader_result_t res);
    int gap;
    gap = 0;
    while (snd_idle_pct > 0 && $urandom_range(99) < snd_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    now_ms    <= stamp;
    do @(posedge clk); while (in_stall);
    res = fader_advance(op, stamp);
  endtask

  // hold input until every expected beat is back, then idle a while
  task automatic wait_drained(input int extra);
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] got_val);
    if (exp_val !== got_val) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, exp_val, got_val);
      mismatches++;
    end
  endtask

  // result side back-pressure
  always @(posedge clk) begin
    out_stall <= (rcv_idle_pct > 0) && ($urandom_range(99) < rcv_idle_pct);
  end

  // result beat check
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, got %0d %0d %0d %0d",
                 $time, intensity, period_ms, tempo_updated, press_accepted);
        mismatches++;
      end else begin
        head_result = due_results.pop_front();
        check_field("intensity", 32'(head_result.intensity), 32'(intensity));
        check_field("period_ms", 32'(head_result.period), 32'(period_ms));
        check_field("tempo_updated", 32'(head_result.updated), 32'(tempo_updated));
        check_field("press_accepted", 32'(head_result.accepted),
                    32'(press_accepted));
      end
    end
  end

  // stimulus
  initial begin
    int               k;
    int               n;
    int               r;
    bit               paused;
    logic             op;
    logic [NOW_W-1:0] stamp;
    logic [NOW_W-1:0] run_ms;
    logic [NOW_W-1:0] lo_b;
    fader_result_t    res;
    fader_model_reset();
    snd_idle_pct = 33;
    rcv_idle_pct = 53;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed rows at reset settings
    foreach (dir_rows[i]) begin
      send_beat(dir_rows[i].op, dir_rows[i].stamp, res);
      expect_result(dir_rows[i].fixed ? dir_rows[i].want : res);
    end
    run_ms = dir_rows[N_ROWS-1].stamp;

    // random runs, one register setting each
    for (k = 0; k < N_SETTINGS; k++) begin
      wait_drained(8);
      apply_setting(k);
      case (k / 2)
        0: begin
          snd_idle_pct = 33; rcv_idle_pct = 53;
        end
        1: begin
          snd_idle_pct = 53; rcv_idle_pct = 33;
        end
        default: begin
          snd_idle_pct = 0; rcv_idle_pct = 0;
        end
      endcase
      n = 0;
      paused = 1'b0;
      while (n < RUN_ITEMS) begin
        r = $urandom_range(99);
        if (r < 40) begin
          // fades moving forward in time
          op = OP_FADE;
          stamp = run_ms + $urandom_range(0, 2 * tempo_ms);
        end else if (r < 60) begin
          // taps at arbitrary spacing
          op = OP_PRESS;
          stamp = run_ms + $urandom_range(1, 4200);
        end else if (r < 72) begin
          // taps on and next to the period limits
          op = OP_PRESS;
          lo_b = (tap_min == '0) ? NOW_W'(1) : NOW_W'(tap_min);
          stamp = last_tap_ms + ($urandom_range(1) ? lo_b : NOW_W'(tap_max))
                  + $urandom_range(2) - 1;
        end else if (r < 85) begin
          // presses around the debounce edge
          op = OP_PRESS;
          stamp = last_press_ms + $urandom_range(0, deb_win + 2);
        end else if (r < 95) begin
          op = 1'($urandom_range(1));
          stamp = $urandom();
        end else begin
          // zero stamps and stamps just before the wrap
          op = 1'($urandom_range(1));
          stamp = $urandom_range(1) ? '0 : 32'hFFFF_FFFF - $urandom_range(300);
        end
        run_ms = stamp;
        send_beat(op, stamp, res);
        expect_result(res);
        n++;
        if (!paused && n >= RUN_ITEMS / 2) begin
          wait_drained(0);
          paused = 1'b1;
        end
      end
    end

    wait_drained(DRAIN_CYCLES);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
